>>> design/rbb_pkg.sv
// rbb_pkg: widths, register indexes and pipeline depth for the brake blend
// no dependencies; imported by regen_hydraulic_brake_blend
package rbb_pkg;

  // force and pedal formats
  localparam int FORCE_BITS   = 20;
  localparam int FRAC_BITS    = 16;
  localparam int PEDAL_BITS   = FRAC_BITS + 2;
  localparam int SPEED_BITS   = 16;
  localparam int FADE_BITS    = 15;
  localparam int AVAIL_BITS   = FORCE_BITS + 1;
  localparam int PROD_BITS    = FORCE_BITS + FADE_BITS;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = FORCE_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_TOTAL  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_REGEN  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_SPEED = CFG_IDX_BITS'(2);

  // pedal full scale, 1.0 in q1.FRAC_BITS
  localparam logic [FRAC_BITS:0] PEDAL_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // fade divider: quotient bits resolved per stage
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = (FORCE_BITS + DIV_STEP - 1) / DIV_STEP;

  // input register, two multiply stages, min stage, divider, output register
  localparam int LATENCY = DIV_STAGES + 5;

endpackage

>>> design/regen_hydraulic_brake_blend.sv
// regen_hydraulic_brake_blend: pipelined split of brake demand into regen and friction
// depends on rbb_pkg for widths, register indexes and divider depth
//
// usage
//   configuration: cfg_we_i with cfg_idx_i / cfg_wdata_i writes one register per
//   cycle (0 max total force, 1 max regen force, 2 regen fade speed); writes to
//   index 3 are dropped, data above a register's width is ignored. write only
//   while no word is in flight
//   input: a word is taken at every clock edge with start_i high and busy_o low;
//   busy_o is always low, so a new word may enter every cycle
//   output: each word returns after stages 0 to 3, the divider stages and the output
//   register as a one-cycle done_o strobe with regen, hydraulic and total force; the
//   receiver cannot hold it off, and the pipeline never stalls
//   throughput: one word per cycle; most of the depth is the restoring fade divider
//   (two quotient bits per stage, ten stages) behind the two multiply stages
//   reset: rst_ni clears all valid bits and the three registers to zero;
//   words in flight are dropped
module regen_hydraulic_brake_blend
  import rbb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  // input words
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [PEDAL_BITS-1:0] pedal_position_i,
  input  logic signed [SPEED_BITS-1:0] vehicle_speed_i,
  input  logic signed [AVAIL_BITS-1:0] regen_available_i,
  // result words
  output logic                     done_o,
  output logic [FORCE_BITS-1:0]    regen_cmd_o,
  output logic [FORCE_BITS-1:0]    friction_cmd_o,
  output logic [FORCE_BITS-1:0]    brake_demand_o
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [FORCE_BITS-1:0] max_total_q;
  logic [FORCE_BITS-1:0] max_regen_q;
  logic [FADE_BITS-1:0]  fade_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_total_q  <= '0;
      max_regen_q  <= '0;
      fade_speed_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_TOTAL:  max_total_q  <= cfg_wdata_i[FORCE_BITS-1:0];
        CFG_MAX_REGEN:  max_regen_q  <= cfg_wdata_i[FORCE_BITS-1:0];
        CFG_FADE_SPEED: fade_speed_q <= cfg_wdata_i[FADE_BITS-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  // the pipeline never holds off a word
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------------------
  // stage 0: clamp pedal and regen, take speed magnitude
  // ---------------------------------------------------------------------------
  logic                  s0_vld_q;
  logic [FRAC_BITS:0]    s0_pedal_q, s0_pedal_d;
  logic [SPEED_BITS-1:0] s0_speed_q, s0_speed_d;
  logic [FORCE_BITS-1:0] s0_avail_q, s0_avail_d;

  always_comb begin
    priority if (pedal_position_i[PEDAL_BITS-1]) begin
      s0_pedal_d = '0;
    end else if (pedal_position_i[PEDAL_BITS-2:0] > PEDAL_ONE) begin
      s0_pedal_d = PEDAL_ONE;
    end else begin
      s0_pedal_d = pedal_position_i[PEDAL_BITS-2:0];
    end

    // most negative speed wraps to its exact magnitude
    if (vehicle_speed_i[SPEED_BITS-1]) begin
      s0_speed_d = ~vehicle_speed_i + SPEED_BITS'(1);
    end else begin
      s0_speed_d = vehicle_speed_i;
    end

    if (regen_available_i[AVAIL_BITS-1]) begin
      s0_avail_d = '0;
    end else begin
      s0_avail_d = regen_available_i[FORCE_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: pedal products, fade bypass decision
  // ---------------------------------------------------------------------------
  logic                              s1_vld_q;
  logic [FORCE_BITS-1:0]             s1_total_q, s1_total_d;
  logic [FORCE_BITS-1:0]             s1_rlim_q, s1_rlim_d;
  logic [FORCE_BITS-1:0]             s1_avail_q;
  logic [FADE_BITS-1:0]              s1_speed_q;
  logic                              s1_byp_q, s1_byp_d;
  logic [FRAC_BITS+FORCE_BITS:0]     prod_total, prod_rlim;

  always_comb begin
    prod_total = s0_pedal_q * max_total_q;
    prod_rlim  = s0_pedal_q * max_regen_q;
    // pedal <= 1.0, so the truncated product never exceeds the maximum
    s1_total_d = prod_total[FRAC_BITS +: FORCE_BITS];
    s1_rlim_d  = prod_rlim[FRAC_BITS +: FORCE_BITS];
    // full regen when fading is off or speed is at or above the fade speed
    s1_byp_d   = (fade_speed_q == '0) || (s0_speed_q >= {1'b0, fade_speed_q});
  end

  // ---------------------------------------------------------------------------
  // stage 2: regen capacity as the least of three limits
  // ---------------------------------------------------------------------------
  logic                  s2_vld_q;
  logic [FORCE_BITS-1:0] s2_cap_q, s2_cap_d;
  logic [FORCE_BITS-1:0] s2_total_q;
  logic [FADE_BITS-1:0]  s2_speed_q;
  logic                  s2_byp_q;
  logic [FORCE_BITS-1:0] min_tr;

  always_comb begin
    min_tr   = (s1_total_q < s1_rlim_q) ? s1_total_q : s1_rlim_q;
    s2_cap_d = (min_tr < s1_avail_q) ? min_tr : s1_avail_q;
  end

  // ---------------------------------------------------------------------------
  // stage 3: cap times speed, the fade dividend
  // ---------------------------------------------------------------------------
  logic                  s3_vld_q;
  logic [PROD_BITS-1:0]  s3_prod_q;
  logic [FORCE_BITS-1:0] s3_cap_q;
  logic [FORCE_BITS-1:0] s3_total_q;
  logic                  s3_byp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= accept;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_pedal_q <= s0_pedal_d;
    s0_speed_q <= s0_speed_d;
    s0_avail_q <= s0_avail_d;

    s1_total_q <= s1_total_d;
    s1_rlim_q  <= s1_rlim_d;
    s1_avail_q <= s0_avail_q;
    // only used below the fade speed, where the magnitude fits
    s1_speed_q <= s0_speed_q[FADE_BITS-1:0];
    s1_byp_q   <= s1_byp_d;

    s2_cap_q   <= s2_cap_d;
    s2_total_q <= s1_total_q;
    s2_speed_q <= s1_speed_q;
    s2_byp_q   <= s1_byp_q;

    s3_prod_q  <= s2_cap_q * s2_speed_q;
    s3_cap_q   <= s2_cap_q;
    s3_total_q <= s2_total_q;
    s3_byp_q   <= s2_byp_q;
  end

  // ---------------------------------------------------------------------------
  // fade divider: restoring division by the fade speed, DIV_STEP bits a stage
  // speed < fade speed gives a quotient below cap, so FORCE_BITS bits suffice
  // and the top FADE_BITS of the dividend are already below the divisor
  // the low dividend bits shift out of acc as quotient bits shift in
  // ---------------------------------------------------------------------------
  logic                  dv_vld_q   [DIV_STAGES];
  logic [FADE_BITS-1:0]  dv_rem_q   [DIV_STAGES];
  logic [FORCE_BITS-1:0] dv_acc_q   [DIV_STAGES];
  logic [FORCE_BITS-1:0] dv_cap_q   [DIV_STAGES];
  logic [FORCE_BITS-1:0] dv_total_q [DIV_STAGES];
  logic                  dv_byp_q   [DIV_STAGES];

  logic [FADE_BITS-1:0]  dv_rem_d   [DIV_STAGES];
  logic [FORCE_BITS-1:0] dv_acc_d   [DIV_STAGES];

  always_comb begin
    logic [FADE_BITS-1:0]  rem;
    logic [FORCE_BITS-1:0] acc;
    logic [FADE_BITS:0]    trial;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        rem = s3_prod_q[PROD_BITS-1:FORCE_BITS];
        acc = s3_prod_q[FORCE_BITS-1:0];
      end else begin
        rem = dv_rem_q[s-1];
        acc = dv_acc_q[s-1];
      end
      for (int j = 0; j < DIV_STEP; j++) begin
        if (s * DIV_STEP + j < FORCE_BITS) begin
          trial = {rem, acc[FORCE_BITS-1]};
          if (trial >= {1'b0, fade_speed_q}) begin
            rem = FADE_BITS'(trial - {1'b0, fade_speed_q});
            acc = {acc[FORCE_BITS-2:0], 1'b1};
          end else begin
            rem = trial[FADE_BITS-1:0];
            acc = {acc[FORCE_BITS-2:0], 1'b0};
          end
        end
      end
      dv_rem_d[s] = rem;
      dv_acc_d[s] = acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        dv_vld_q[s] <= 1'b0;
      end
    end else begin
      dv_vld_q[0] <= s3_vld_q;
      for (int s = 1; s < DIV_STAGES; s++) begin
        dv_vld_q[s] <= dv_vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dv_cap_q[0]   <= s3_cap_q;
    dv_total_q[0] <= s3_total_q;
    dv_byp_q[0]   <= s3_byp_q;
    for (int s = 1; s < DIV_STAGES; s++) begin
      dv_cap_q[s]   <= dv_cap_q[s-1];
      dv_total_q[s] <= dv_total_q[s-1];
      dv_byp_q[s]   <= dv_byp_q[s-1];
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      dv_rem_q[s] <= dv_rem_d[s];
      dv_acc_q[s] <= dv_acc_d[s];
    end
  end

  // ---------------------------------------------------------------------------
  // output register: pick faded or full regen, friction makes up the rest
  // ---------------------------------------------------------------------------
  logic                  out_vld_q;
  logic [FORCE_BITS-1:0] out_regen_q, out_regen_d;
  logic [FORCE_BITS-1:0] out_hyd_q;
  logic [FORCE_BITS-1:0] out_total_q;

  assign out_regen_d = dv_byp_q[DIV_STAGES-1] ? dv_cap_q[DIV_STAGES-1]
                                              : dv_acc_q[DIV_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dv_vld_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_regen_q <= out_regen_d;
    out_hyd_q   <= dv_total_q[DIV_STAGES-1] - out_regen_d;
    out_total_q <= dv_total_q[DIV_STAGES-1];
  end

  assign done_o         = out_vld_q;
  assign regen_cmd_o    = out_regen_q;
  assign friction_cmd_o = out_hyd_q;
  assign brake_demand_o = out_total_q;

`ifndef NO_ASSERTIONS
  // every accepted word comes out after the fixed latency
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("accepted word did not return after LATENCY cycles");

  // nothing comes out that was not accepted
  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result strobe without matching input word");

  // friction and regen add up to the total demand
  a_force_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (FORCE_BITS'(regen_cmd_o + friction_cmd_o) == brake_demand_o))
    else $error("regen plus hydraulic differs from total");

  // regen never exceeds the total, so hydraulic does not wrap
  a_regen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (regen_cmd_o <= brake_demand_o))
    else $error("regen force above total force");

  // divider remainder stays below the divisor on the faded path
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld_q[DIV_STAGES-1] && !dv_byp_q[DIV_STAGES-1])
      |-> (dv_rem_q[DIV_STAGES-1] < fade_speed_q))
    else $error("fade divider remainder out of range");
`endif

endmodule

>>> tb/regen_hydraulic_brake_blend_test.sv
// regen_hydraulic_brake_blend_test: self-checking bench for the regen / hydraulic brake blend
// depends on rbb_pkg and regen_hydraulic_brake_blend; a scoreboard class predicts each split
`timescale 1ns / 1ps

module regen_hydraulic_brake_blend_test;
  import rbb_pkg::*;

  // index 3 has no register behind it, writes there must be dropped
  localparam logic [CFG_IDX_BITS-1:0] CFG_NO_REG = CFG_IDX_BITS'(3);

  localparam int FORCE_FULL_SCALE = (1 << FORCE_BITS) - 1;
  localparam int MAX_FADE         = (1 << FADE_BITS) - 1;
  localparam int FULL_PEDAL       = 1 << FRAC_BITS;

  typedef logic [FORCE_BITS-1:0] force_t;

  // one expected result word
  typedef struct packed {
    force_t regen;
    force_t hydraulic;
    force_t total;
  } brake_split_t;

  // scoreboard: own copy of the three registers, predicts the split for each
  // accepted demand word and checks result words in order
  class brake_split_board;
    force_t                 max_total;
    force_t                 max_regen;
    logic [FADE_BITS-1:0]   fade_speed;
    brake_split_t           split_due_q[$];
    int                     errors;

    function new();
      max_total  = '0;
      max_regen  = '0;
      fade_speed = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_MAX_TOTAL:  max_total  = data[FORCE_BITS-1:0];
        CFG_MAX_REGEN:  max_regen  = data[FORCE_BITS-1:0];
        CFG_FADE_SPEED: fade_speed = data[FADE_BITS-1:0];
        default: ;
      endcase
    endfunction

    function brake_split_t blend_forces(logic signed [PEDAL_BITS-1:0] p,
                                        logic signed [SPEED_BITS-1:0] v,
                                        logic signed [AVAIL_BITS-1:0] a);
      longint            ps, vs, as;
      longint unsigned   pedal, speed, avail, total, lim, cap, regen;
      brake_split_t      s;
      ps = p;
      vs = v;
      as = a;
      // pedal clamped to 0..1.0, negative regen headroom counts as none
      if (ps < 0) pedal = 0;
      else if (ps > FULL_PEDAL) pedal = FULL_PEDAL;
      else pedal = ps;
      avail = (as < 0) ? 0 : as;
      speed = (vs < 0) ? -vs : vs;
      total = (pedal * max_total) >> FRAC_BITS;
      lim   = (pedal * max_regen) >> FRAC_BITS;
      cap   = (total < lim) ? total : lim;
      if (avail < cap) cap = avail;
      // linear fade below the fade speed, one truncating divide
      if (fade_speed == 0 || speed >= fade_speed) regen = cap;
      else regen = (cap * speed) / fade_speed;
      s.regen     = force_t'(regen);
      s.hydraulic = force_t'(total - regen);
      s.total     = force_t'(total);
      return s;
    endfunction

    function void note_demand(logic signed [PEDAL_BITS-1:0] p,
                              logic signed [SPEED_BITS-1:0] v,
                              logic signed [AVAIL_BITS-1:0] a);
      split_due_q.push_back(blend_forces(p, v, a));
    endfunction

    function void check_split(force_t regen, force_t hydraulic, force_t total);
      brake_split_t e;
      if (split_due_q.size() == 0) begin
        $error("result word with nothing expected: regen %0d hydraulic %0d total %0d",
               regen, hydraulic, total);
        errors++;
        return;
      end
      e = split_due_q.pop_front();
      if (regen !== e.regen) begin
        $error("regen_cmd: expected %0d, got %0d", e.regen, regen);
        errors++;
      end
      if (hydraulic !== e.hydraulic) begin
        $error("friction_cmd: expected %0d, got %0d", e.hydraulic, hydraulic);
        errors++;
      end
      if (total !== e.total) begin
        $error("brake_demand: expected %0d, got %0d", e.total, total);
        errors++;
      end
    endfunction

    function int pending();
      return split_due_q.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [CFG_IDX_BITS-1:0]       cfg_idx_i;
  logic [CFG_DATA_BITS-1:0]      cfg_wdata_i;
  logic                          start_i;
  logic                          busy_o;
  logic signed [PEDAL_BITS-1:0]  pedal_position_i;
  logic signed [SPEED_BITS-1:0]  vehicle_speed_i;
  logic signed [AVAIL_BITS-1:0]  regen_available_i;
  logic                          done_o;
  force_t                        regen_cmd_o;
  force_t                        friction_cmd_o;
  force_t                        brake_demand_o;

  brake_split_board board = new();

  regen_hydraulic_brake_blend DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .pedal_position_i  (pedal_position_i),
    .vehicle_speed_i   (vehicle_speed_i),
    .regen_available_i (regen_available_i),
    .done_o            (done_o),
    .regen_cmd_o       (regen_cmd_o),
    .friction_cmd_o    (friction_cmd_o),
    .brake_demand_o    (brake_demand_o)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // hard stop in case the pipeline hangs or results go missing
  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

  // everything is sampled on the rising edge: register writes and accepted
  // demand words feed the model first, then any result word is checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        board.write_reg(cfg_idx_i, cfg_wdata_i);
      end
      if (start_i && !busy_o) begin
        board.note_demand(pedal_position_i, vehicle_speed_i, regen_available_i);
      end
      if (done_o) begin
        board.check_split(regen_cmd_o, friction_cmd_o, brake_demand_o);
      end
    end
  end

  // one demand word, held until the block takes it
  task automatic send_demand(input logic signed [PEDAL_BITS-1:0] p,
                             input logic signed [SPEED_BITS-1:0] v,
                             input logic signed [AVAIL_BITS-1:0] a);
    @(negedge clk_i);
    start_i           <= 1'b1;
    pedal_position_i  <= p;
    vehicle_speed_i   <= v;
    regen_available_i <= a;
    do begin
      @(posedge clk_i);
    end while (busy_o);
  endtask

  // sender gap; the fields carry junk meanwhile, which must be ignored
  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      start_i           <= 1'b0;
      pedal_position_i  <= PEDAL_BITS'($urandom);
      vehicle_speed_i   <= SPEED_BITS'($urandom);
      regen_available_i <= AVAIL_BITS'($urandom);
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // stop sending and wait for every outstanding result word
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // register writes on consecutive cycles; only called with the pipeline empty
  task automatic write_regs(input logic [CFG_DATA_BITS-1:0] total_max,
                            input logic [CFG_DATA_BITS-1:0] regen_max,
                            input logic [CFG_DATA_BITS-1:0] fade,
                            input bit poke_spare);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MAX_TOTAL;
    cfg_wdata_i <= total_max;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_MAX_REGEN;
    cfg_wdata_i <= regen_max;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_FADE_SPEED;
    cfg_wdata_i <= fade;
    if (poke_spare) begin
      // junk to the unused index must leave all three registers alone
      @(negedge clk_i);
      cfg_idx_i   <= CFG_NO_REG;
      cfg_wdata_i <= CFG_DATA_BITS'($urandom);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random demand word: mostly pedal in range, speeds around the fade point
  // and real regen headroom, with a share of full-range noise on every field
  task automatic send_random_demand();
    int                           fade, mag, pick;
    logic signed [PEDAL_BITS-1:0] p;
    logic signed [SPEED_BITS-1:0] v;
    logic signed [AVAIL_BITS-1:0] a;
    fade = board.fade_speed;

    pick = $urandom_range(0, 9);
    if (pick == 0) p = PEDAL_BITS'($urandom);
    else if (pick == 1) p = PEDAL_BITS'(FULL_PEDAL + $urandom_range(0, 2) - 1);
    else if (pick == 2) p = PEDAL_BITS'($urandom_range(0, 2)) - PEDAL_BITS'(1);
    else p = PEDAL_BITS'($urandom_range(0, FULL_PEDAL));

    pick = $urandom_range(0, 9);
    if (pick < 2 || fade == 0) begin
      v = SPEED_BITS'($urandom);
    end else begin
      if (pick < 4) mag = fade + $urandom_range(0, 6) - 3;
      else mag = $urandom_range(0, 2 * fade);
      if (mag < 0) mag = 0;
      if (mag > 32768) mag = 32768;
      // 32768 with a plus sign wraps to the most negative speed, same magnitude
      v = ($urandom_range(0, 1) == 1) ? SPEED_BITS'(-mag) : SPEED_BITS'(mag);
    end

    pick = $urandom_range(0, 9);
    if (pick < 2) a = AVAIL_BITS'($urandom);
    else if (pick < 4) a = AVAIL_BITS'($urandom_range(0, 4000));
    else a = AVAIL_BITS'($urandom_range(0, FORCE_FULL_SCALE));

    send_demand(p, v, a);
  endtask

  // random words in bursts; steady runs back to back, pause_half drains midway
  task automatic run_random(input int count, input bit steady, input bit pause_half);
    int  left, burst;
    bit  paused;
    left   = count;
    paused = 1'b0;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) send_random_demand();
      left -= burst;
      if (left > 0) begin
        if (pause_half && !paused && left < count / 2) begin
          drain();
          paused = 1'b1;
        end else if (!steady) begin
          if ($urandom_range(0, 9) == 0) hold_off($urandom_range(15, 40));
          else hold_off($urandom_range(1, 8));
        end
      end
    end
  endtask

  // directed demand words: pedal, speed and regen headroom extremes, the
  // fade boundary and below it, against a 2560 (10 m/s) fade speed
  int dir_pedal [17] = '{65536, 131071, -131072, -1, 0, 1, 65535, 65537, 65536,
                         65536, 65536, 65536, 65536, 65536, 65536, 65536, 40000};
  int dir_speed [17] = '{2560, 32767, -32768, 100, 5000, 5000, 5000, 5000, -32768,
                         3000, 3000, 3000, 1280, -1280, 0, 2559, -2561};
  int dir_avail [17] = '{1048575, 1048575, 1048575, 5000, 5000, 1048575, 1048575,
                         1048575, -1048576, -1, 0, 100, 1048575, 1048575, 1048575,
                         1048575, 300000};

  initial begin
    int k;
    logic [CFG_DATA_BITS-1:0] fade_w;

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_MAX_TOTAL;
    cfg_wdata_i       = '0;
    start_i           = 1'b0;
    pedal_position_i  = '0;
    vehicle_speed_i   = '0;
    regen_available_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // registers still at reset: every force must come out zero
    send_demand(PEDAL_BITS'(FULL_PEDAL), 16'sd1000, 21'sd500000);
    send_demand(PEDAL_BITS'(131071), -16'sd32768, 21'sd1048575);
    drain();

    write_regs(CFG_DATA_BITS'(1000000), CFG_DATA_BITS'(600000), CFG_DATA_BITS'(2560), 1'b0);
    for (k = 0; k < 17; k++) begin
      send_demand(PEDAL_BITS'(dir_pedal[k]), SPEED_BITS'(dir_speed[k]),
                  AVAIL_BITS'(dir_avail[k]));
    end
    drain();

    // fading switched off: regen equals the capacity even at standstill
    write_regs(CFG_DATA_BITS'(1000000), CFG_DATA_BITS'(600000), '0, 1'b0);
    send_demand(PEDAL_BITS'(FULL_PEDAL), 16'sd0, 21'sd1048575);
    send_demand(PEDAL_BITS'(30000), -16'sd1, 21'sd1048575);
    drain();

    // random phases, each under its own register setting
    for (k = 0; k < 8; k++) begin
      fade_w = CFG_DATA_BITS'($urandom_range(1, 8000));
      case (k)
        0: write_regs(CFG_DATA_BITS'(FORCE_FULL_SCALE), CFG_DATA_BITS'(FORCE_FULL_SCALE),
                      CFG_DATA_BITS'(MAX_FADE), 1'b0);
        1: write_regs(CFG_DATA_BITS'($urandom_range(0, FORCE_FULL_SCALE)),
                      CFG_DATA_BITS'($urandom_range(0, FORCE_FULL_SCALE)), '0, 1'b0);
        2: write_regs(CFG_DATA_BITS'($urandom_range(0, FORCE_FULL_SCALE)),
                      CFG_DATA_BITS'(FORCE_FULL_SCALE), CFG_DATA_BITS'(1), 1'b0);
        3: write_regs('0, '0, '0, 1'b1);
        // regen limit above the total, so the total caps the capacity
        4: write_regs(CFG_DATA_BITS'($urandom_range(0, 300000)),
                      CFG_DATA_BITS'($urandom_range(300000, FORCE_FULL_SCALE)), fade_w, 1'b1);
        default: begin
          // upper data bits on the fade register are junk and get masked
          fade_w[CFG_DATA_BITS-1:FADE_BITS] = ($urandom_range(0, 1) == 1) ?
                                              (CFG_DATA_BITS - FADE_BITS)'($urandom) : '0;
          write_regs(CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom), fade_w, k == 6);
        end
      endcase
      run_random(175, k == 3 || k == 6, k == 4);
      drain();
    end

    // quiet tail: any stray result word is caught by the monitor
    repeat (LATENCY + 10) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
